>>> hw/rtl/ccw_pkg.sv
// Shared types, codes and constant tables for the character-LCD cursor writer.
package ccw_pkg;

   // default geometry of the display
   localparam int DEFAULT_ROW_COUNT    = 2;
   localparam int DEFAULT_COLUMN_COUNT = 16;

   // stream widths
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // initialization sequence
   localparam int INIT_LEN = 8;
   localparam int STEP_W   = $clog2(INIT_LEN);

   // request kinds
   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_INIT  = 2'd3;

   // special characters
   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_LF = 8'd10;

   // instruction bytes
   localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
   localparam logic [7:0] LCD_ROW1_BASE = 8'h40;
   localparam logic [7:0] LCD_CLEAR     = 8'h01;
   localparam logic [7:0] LCD_HOME      = 8'h02;

   // waits in microseconds
   localparam logic [12:0] WAIT_SHORT      = 13'd50;
   localparam logic [12:0] WAIT_LONG       = 13'd2000;
   localparam logic [15:0] WAIT_INIT_FIRST = 16'd40000;

   // register select codes
   localparam logic RS_INSTR = 1'b0;
   localparam logic RS_DATA  = 1'b1;

   // what the back end has to do for one accepted request
   typedef enum logic [2:0] {
      JOB_DATA,
      JOB_ADDR,
      JOB_ADDR_DATA,
      JOB_CLEAR,
      JOB_INIT
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   addr_byte;
      logic [7:0]   char_byte;
   } ccw_job_type;

   // set-DDRAM-address command for a cursor position
   function automatic logic [7:0] addr_cmd(input logic row_nonzero, input logic [7:0] col);
      logic [7:0] addr;
      addr = row_nonzero ? (LCD_ROW1_BASE + col) : col;
      return LCD_SET_DDRAM | addr;
   endfunction

   // instruction bytes of the initialization sequence
   function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h30;
         3'd1:    b = 8'h30;
         3'd2:    b = 8'h30;
         3'd3:    b = 8'h38;
         3'd4:    b = 8'h08;
         3'd5:    b = LCD_CLEAR;
         3'd6:    b = 8'h06;
         3'd7:    b = 8'h0c;
         default: b = 8'h30;
      endcase
      return b;
   endfunction

   // waits after each initialization write, extra settle times included
   function automatic logic [12:0] init_after(input logic [STEP_W-1:0] idx);
      logic [12:0] w;
      case (idx)
         3'd0:    w = 13'd5050;
         3'd1:    w = 13'd200;
         3'd5:    w = WAIT_LONG;
         default: w = WAIT_SHORT;
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/ccw_front.sv
// Front end: accepts requests, tracks the cursor and classifies each request into a job.
module ccw_front
   import ccw_pkg::*;
#(
   parameter int ROW_COUNT    = DEFAULT_ROW_COUNT,
   parameter int COLUMN_COUNT = DEFAULT_COLUMN_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [1:0]  cmd,
   input  logic [7:0]  char_code,
   input  logic [7:0]  row,
   input  logic [7:0]  column,
   output logic        push,
   output ccw_job_type job
);

   localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int COL_W = $clog2(COLUMN_COUNT + 1);

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] next_row;
   logic [7:0]       clamp_row;
   logic [7:0]       clamp_col;
   logic             keep;

   // row after a wrap, modulo the row count
   assign next_row = (row_ff == ROW_W'(ROW_COUNT - 1)) ? '0 : row_ff + 1'b1;

   // set-cursor clamping
   assign clamp_row = (row >= 8'(ROW_COUNT)) ? 8'(ROW_COUNT - 1) : row;
   assign clamp_col = (column >= 8'(COLUMN_COUNT)) ? 8'(COLUMN_COUNT - 1) : column;

   // classify the request and work out the new cursor
   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      keep          = 1'b1;
      job.kind      = JOB_DATA;
      job.addr_byte = addr_cmd(1'b0, 8'd0);
      job.char_byte = char_code;
      case (cmd)
         CMD_PUT: begin
            if (char_code == CHAR_CR) begin
               keep = 1'b0;
            end else if (char_code == CHAR_LF) begin
               row_in        = next_row;
               col_in        = '0;
               job.kind      = JOB_ADDR;
               job.addr_byte = addr_cmd(next_row != '0, 8'd0);
            end else if (col_ff >= COL_W'(COLUMN_COUNT)) begin
               row_in        = next_row;
               col_in        = COL_W'(1);
               job.kind      = JOB_ADDR_DATA;
               job.addr_byte = addr_cmd(next_row != '0, 8'd0);
            end else begin
               col_in   = col_ff + 1'b1;
               job.kind = JOB_DATA;
            end
         end
         CMD_SET: begin
            row_in        = clamp_row[ROW_W-1:0];
            col_in        = clamp_col[COL_W-1:0];
            job.kind      = JOB_ADDR;
            job.addr_byte = addr_cmd(clamp_row != 8'd0, clamp_col);
         end
         CMD_CLEAR: begin
            row_in   = '0;
            col_in   = '0;
            job.kind = JOB_CLEAR;
         end
         default: begin
            row_in   = '0;
            col_in   = '0;
            job.kind = JOB_INIT;
         end
      endcase
   end

   assign push = accept && keep;

   // cursor registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= ROW_W'(ROW_COUNT - 1))
      else $error("cursor row beyond last row");

   a_cr_no_job: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == CMD_PUT && char_code == CHAR_CR |=> $stable(col_ff) && $stable(row_ff))
      else $error("carriage return moved the cursor");

endmodule

>>> hw/rtl/ccw_queue.sv
// Short job queue between the front end and the write sequencer.
module ccw_queue
   import ccw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ccw_job_type push_job,
   output logic        full,
   input  logic        pop,
   output logic        not_empty,
   output ccw_job_type head_job
);

   ccw_job_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("job queue underflow");

endmodule

>>> hw/rtl/ccw_back.sv
// Back end: steps through jobs; one write per cycle into the output register unless stalled.
module ccw_back
   import ccw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  ccw_job_type job,
   output logic        pop,
   output logic        out_valid,
   input  logic        out_ready,
   output logic        out_rs,
   output logic [7:0]  out_byte,
   output logic [15:0] out_before,
   output logic [12:0] out_after,
   output logic        out_last
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic              rs_ff, rs_in;
   logic [7:0]        byte_ff, byte_in;
   logic [15:0]       before_ff, before_in;
   logic [12:0]       after_ff, after_in;
   logic              last_ff, last_in;
   logic              slot_free;
   logic              emit;

   assign slot_free = !valid_ff || out_ready;
   assign emit      = job_valid && slot_free;
   assign pop       = emit && last_in;

   // write for the current step of the job
   always_comb begin
      rs_in     = RS_INSTR;
      byte_in   = job.addr_byte;
      before_in = '0;
      after_in  = WAIT_SHORT;
      last_in   = 1'b1;
      case (job.kind)
         JOB_DATA: begin
            rs_in   = RS_DATA;
            byte_in = job.char_byte;
         end
         JOB_ADDR: begin
            byte_in = job.addr_byte;
         end
         JOB_ADDR_DATA: begin
            if (step_ff == '0) begin
               last_in = 1'b0;
            end else begin
               rs_in   = RS_DATA;
               byte_in = job.char_byte;
            end
         end
         JOB_CLEAR: begin
            byte_in  = LCD_CLEAR;
            after_in = WAIT_LONG;
         end
         JOB_INIT: begin
            byte_in   = init_byte(step_ff);
            before_in = (step_ff == '0) ? WAIT_INIT_FIRST : 16'd0;
            after_in  = init_after(step_ff);
            last_in   = (step_ff == STEP_W'(INIT_LEN - 1));
         end
         default: begin
            byte_in = job.addr_byte;
         end
      endcase
   end

   // step counter and output valid
   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (emit) step_in = last_in ? '0 : step_ff + 1'b1;
      if (slot_free) valid_in = job_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (emit) begin
         rs_ff     <= rs_in;
         byte_ff   <= byte_in;
         before_ff <= before_in;
         after_ff  <= after_in;
         last_ff   <= last_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_rs     = rs_ff;
   assign out_byte   = byte_ff;
   assign out_before = before_ff;
   assign out_after  = after_ff;
   assign out_last   = last_ff;

   a_step_kind: assert property (@(posedge clock) disable iff (reset)
      step_ff != '0 |-> job_valid && (job.kind == JOB_INIT || job.kind == JOB_ADDR_DATA))
      else $error("step counter active on single-write job");

   a_long_wait_init: assert property (@(posedge clock) disable iff (reset)
      valid_ff && before_ff != 16'd0 |-> rs_ff == RS_INSTR && byte_ff == 8'h30 && !last_ff)
      else $error("wait before a write other than first init write");

endmodule

>>> hw/rtl/char_lcd_cursor_writer_core.sv
// Character-LCD cursor writer: turns put, set-cursor, clear and init requests into bus writes.
// Requests enter on req_ and are classified by the front end in the cycle they are accepted;
// a request is taken every cycle while the two-entry job queue has room. The back-end
// sequencer emits one bus write per cycle, unless rsp_tready stalls it, into a registered
// output; a put character is one write, a wrapping put two, and an initialize request eight.
// The first write of a request passes through the job queue and the output register before
// it is presented on rsp_.
// Carriage return is accepted and produces no write. Each write carries rsp_tuser as register
// select (0 instruction, 1 data) and rsp_tlast on the final write of its request.
module char_lcd_cursor_writer_core
   import ccw_pkg::*;
#(
   parameter int ROW_COUNT    = DEFAULT_ROW_COUNT,
   parameter int COLUMN_COUNT = DEFAULT_COLUMN_COUNT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // char_code[7:0], row[15:8], column[23:16]
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // cmd[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // bus_byte[7:0], wait_before_us[23:8],
                                              // wait_after_us[36:24], zero[39:37]
   output logic                   rsp_tuser,  // reg_select
   output logic                   rsp_tlast   // last_write
);

   logic        accept;
   logic        push;
   logic        full;
   logic        pop;
   logic        job_valid;
   ccw_job_type front_job;
   ccw_job_type head_job;
   logic [7:0]  bus_byte;
   logic [15:0] wait_before;
   logic [12:0] wait_after;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   ccw_front #(
      .ROW_COUNT    (ROW_COUNT),
      .COLUMN_COUNT (COLUMN_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_tuser[1:0]),
      .char_code (req_tdata[7:0]),
      .row       (req_tdata[15:8]),
      .column    (req_tdata[23:16]),
      .push      (push),
      .job       (front_job)
   );

   ccw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (front_job),
      .full      (full),
      .pop       (pop),
      .not_empty (job_valid),
      .head_job  (head_job)
   );

   ccw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (head_job),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rs     (rsp_tuser),
      .out_byte   (bus_byte),
      .out_before (wait_before),
      .out_after  (wait_after),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, wait_after, wait_before, bus_byte};

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the character-LCD cursor writer core.
`timescale 1ns / 1ps

module tb_top;
   import ccw_pkg::*;

   localparam int LCD_ROWS = 2;
   localparam int LCD_COLS = 16;
   localparam int RAND_PER_PHASE = 96;
   localparam int DIR_STEPS = 23;
   localparam int DRAIN_CYCLES = 40;

   // init sequence bytes and settle waits, step 0 in the lowest slot
   localparam logic [63:0] INIT_BYTES = 64'h0c06_0108_3830_3030;
   localparam logic [127:0] INIT_WAITS = {16'd50, 16'd50, 16'd2000, 16'd50,
                                          16'd50, 16'd50, 16'd200, 16'd5050};

   // one LCD bus write as it leaves the block
   typedef struct packed {
      logic        rs;
      logic [7:0]  bus_byte;
      logic [15:0] wait_before;
      logic [12:0] wait_after;
      logic        last;
   } lcd_write_type;

   // one directed request, with a hand-written write where it is obvious
   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  ch;
      logic [7:0]  rq_row;
      logic [7:0]  rq_col;
      logic        typed;
      logic        t_rs;
      logic [7:0]  t_byte;
      logic [12:0] t_after;
   } lcd_step_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;  // char_code[7:0], row[15:8], column[23:16]
   logic [REQ_TUSER_W-1:0] req_tuser;  // cmd[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // bus_byte[7:0], wait_before_us[23:8],
                                       // wait_after_us[36:24], zero[39:37]
   logic                   rsp_tuser;  // reg_select
   logic                   rsp_tlast;  // last_write

   lcd_write_type pending_writes[$];
   lcd_step_type  directed_steps[DIR_STEPS];

   // cursor tracked by the predictor
   logic       cur_row;
   logic [4:0] cur_col;

   int error_count = 0;
   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int n_requests = 0;
   int n_writes = 0;
   int n_inits = 0;
   int n_wraps = 0;
   int last_predicted = 0;

   char_lcd_cursor_writer_core #(
      .ROW_COUNT   (LCD_ROWS),
      .COLUMN_COUNT(LCD_COLS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always #6 clock = ~clock;

   // run limit, far above the slowest legal run
   initial begin
      #8_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   // wait after an instruction byte
   function automatic logic [12:0] instr_wait(input logic [7:0] b);
      return (b == LCD_CLEAR || b == LCD_HOME) ? WAIT_LONG : WAIT_SHORT;
   endfunction

   // set-DDRAM-address byte for the tracked cursor
   function automatic logic [7:0] ddram_cmd();
      logic [7:0] col8;
      col8 = {3'b000, cur_col};
      return LCD_SET_DDRAM | (cur_row ? (LCD_ROW1_BASE + col8) : col8);
   endfunction

   function automatic void push_write(input logic rs, input logic [7:0] b,
                                      input logic [15:0] pre_wait,
                                      input logic [12:0] after);
      lcd_write_type w;
      w.rs = rs;
      w.bus_byte = b;
      w.wait_before = pre_wait;
      w.wait_after = after;
      w.last = 1'b0;
      pending_writes.push_back(w);
   endfunction

   function automatic void advance_row();
      cur_row = 1'((int'(cur_row) + 1) % LCD_ROWS);
      cur_col = 5'd0;
   endfunction

   // expected bus writes for one accepted request; updates the cursor
   function automatic void predict_writes(input logic [1:0] cmd, input logic [7:0] ch,
                                          input logic [7:0] rq_row,
                                          input logic [7:0] rq_col);
      int first;
      logic [7:0] b;
      first = pending_writes.size();
      case (cmd)
         CMD_PUT: begin
            if (ch == CHAR_LF) begin
               advance_row();
               b = ddram_cmd();
               push_write(RS_INSTR, b, 16'd0, instr_wait(b));
            end else if (ch != CHAR_CR) begin
               // full row wraps before the character goes out
               if (cur_col >= LCD_COLS) begin
                  n_wraps++;
                  advance_row();
                  b = ddram_cmd();
                  push_write(RS_INSTR, b, 16'd0, instr_wait(b));
               end
               push_write(RS_DATA, ch, 16'd0, WAIT_SHORT);
               cur_col = cur_col + 5'd1;
            end
         end
         CMD_SET: begin
            cur_row = (rq_row >= LCD_ROWS) ? 1'(LCD_ROWS - 1) : rq_row[0];
            cur_col = (rq_col >= LCD_COLS) ? 5'(LCD_COLS - 1) : rq_col[4:0];
            b = ddram_cmd();
            push_write(RS_INSTR, b, 16'd0, instr_wait(b));
         end
         CMD_CLEAR: begin
            push_write(RS_INSTR, LCD_CLEAR, 16'd0, instr_wait(LCD_CLEAR));
            cur_row = 1'b0;
            cur_col = 5'd0;
         end
         default: begin
            n_inits++;
            cur_row = 1'b0;
            cur_col = 5'd0;
            for (int i = 0; i < 8; i++)
               push_write(RS_INSTR, INIT_BYTES[8*i +: 8],
                          (i == 0) ? WAIT_INIT_FIRST : 16'd0, INIT_WAITS[16*i +: 13]);
         end
      endcase
      last_predicted = pending_writes.size() - first;
      if (pending_writes.size() > first)
         pending_writes[pending_writes.size()-1].last = 1'b1;
   endfunction

   // drive one request at falling edges, return once it is accepted
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch,
                               input logic [7:0] rq_row, input logic [7:0] rq_col);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= REQ_TDATA_W'($urandom);
         req_tuser <= REQ_TUSER_W'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {rq_col, rq_row, ch};
      req_tuser <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_requests++;
      predict_writes(cmd, ch, rq_row, rq_col);
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // check every accepted write against the oldest expectation
   always @(posedge clock) begin
      lcd_write_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("write rs=%0d byte=%02h with nothing pending",
                                      rsp_tuser, rsp_tdata[7:0]));
         end else begin
            exp_w = pending_writes.pop_front();
            n_writes++;
            if (rsp_tuser !== exp_w.rs)
               report_mismatch($sformatf("reg_select got %0d want %0d",
                                         rsp_tuser, exp_w.rs));
            if (rsp_tdata[7:0] !== exp_w.bus_byte)
               report_mismatch($sformatf("bus_byte got %02h want %02h",
                                         rsp_tdata[7:0], exp_w.bus_byte));
            if (rsp_tdata[23:8] !== exp_w.wait_before)
               report_mismatch($sformatf("wait_before got %0d want %0d (byte %02h)",
                                         rsp_tdata[23:8], exp_w.wait_before,
                                         exp_w.bus_byte));
            if (rsp_tdata[36:24] !== exp_w.wait_after)
               report_mismatch($sformatf("wait_after got %0d want %0d (byte %02h)",
                                         rsp_tdata[36:24], exp_w.wait_after,
                                         exp_w.bus_byte));
            if (rsp_tdata[39:37] !== 3'b000)
               report_mismatch($sformatf("tdata pad bits got %b", rsp_tdata[39:37]));
            if (rsp_tlast !== exp_w.last)
               report_mismatch($sformatf("last_write got %0d want %0d (byte %02h)",
                                         rsp_tlast, exp_w.last, exp_w.bus_byte));
         end
      end
   end

   // stimulus
   initial begin
      logic [1:0] cmd;
      logic [7:0] ch;
      logic [7:0] rq_row;
      logic [7:0] rq_col;
      int pick;
      int counted;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      cur_row = 1'b0;
      cur_col = 5'd0;

      // cmd, char, row, column, typed, rs, byte, wait after
      directed_steps = '{
         // first character after reset lands at row 0 column 0
         '{CMD_PUT,   8'h41, 8'h00, 8'h00, 1'b1, RS_DATA,  8'h41, WAIT_SHORT},
         '{CMD_PUT,   CHAR_CR, 8'h00, 8'h00, 1'b0, RS_DATA, 8'h00, 13'd0},
         '{CMD_PUT,   CHAR_LF, 8'h00, 8'h00, 1'b1, RS_INSTR, 8'hc0, WAIT_SHORT},
         // both coordinates clamped
         '{CMD_SET,   8'h00, 8'hff, 8'hff, 1'b1, RS_INSTR, 8'hcf, WAIT_SHORT},
         '{CMD_PUT,   8'hff, 8'h00, 8'h00, 1'b0, RS_DATA,  8'h00, 13'd0},
         // full last row wraps back to row 0
         '{CMD_PUT,   8'h00, 8'h00, 8'h00, 1'b0, RS_DATA,  8'h00, 13'd0},
         '{CMD_SET,   8'h00, 8'h01, 8'h10, 1'b1, RS_INSTR, 8'hcf, WAIT_SHORT},
         '{CMD_PUT,   8'h20, 8'h00, 8'h00, 1'b0, RS_DATA,  8'h00, 13'd0},
         // newline on a full row
         '{CMD_PUT,   CHAR_LF, 8'h00, 8'h00, 1'b1, RS_INSTR, 8'h80, WAIT_SHORT},
         '{CMD_SET,   8'h00, 8'h00, 8'h0f, 1'b1, RS_INSTR, 8'h8f, WAIT_SHORT},
         '{CMD_PUT,   8'h7e, 8'h00, 8'h00, 1'b0, RS_DATA,  8'h00, 13'd0},
         // carriage return leaves the full row as it is
         '{CMD_PUT,   CHAR_CR, 8'hff, 8'hff, 1'b0, RS_DATA, 8'h00, 13'd0},
         '{CMD_PUT,   8'h80, 8'h00, 8'h00, 1'b0, RS_DATA,  8'h00, 13'd0},
         '{CMD_CLEAR, 8'h00, 8'h00, 8'h00, 1'b1, RS_INSTR, LCD_CLEAR, WAIT_LONG},
         '{CMD_SET,   8'h00, 8'h02, 8'h00, 1'b1, RS_INSTR, 8'hc0, WAIT_SHORT},
         '{CMD_INIT,  8'hff, 8'haa, 8'h55, 1'b0, RS_INSTR, 8'h00, 13'd0},
         // data byte equal to the clear code still waits the short time
         '{CMD_PUT,   8'h01, 8'h00, 8'h00, 1'b1, RS_DATA,  8'h01, WAIT_SHORT},
         '{CMD_SET,   8'hff, 8'h01, 8'h00, 1'b1, RS_INSTR, 8'hc0, WAIT_SHORT},
         '{CMD_CLEAR, 8'hff, 8'hff, 8'hff, 1'b1, RS_INSTR, LCD_CLEAR, WAIT_LONG},
         '{CMD_INIT,  8'h00, 8'h00, 8'h00, 1'b0, RS_INSTR, 8'h00, 13'd0},
         '{CMD_SET,   8'h00, 8'h00, 8'h00, 1'b1, RS_INSTR, 8'h80, WAIT_SHORT},
         '{CMD_PUT,   CHAR_LF, 8'h00, 8'h00, 1'b1, RS_INSTR, 8'hc0, WAIT_SHORT},
         '{CMD_PUT,   CHAR_LF, 8'h00, 8'h00, 1'b1, RS_INSTR, 8'h80, WAIT_SHORT}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, with slow receiver
      send_gap_pct = 7;
      recv_stall_pct = 69;
      foreach (directed_steps[i]) begin
         send_request(directed_steps[i].cmd, directed_steps[i].ch,
                      directed_steps[i].rq_row, directed_steps[i].rq_col);
         if (directed_steps[i].typed) begin
            // swap the predicted writes of this request for the typed one
            repeat (last_predicted) void'(pending_writes.pop_back());
            push_write(directed_steps[i].t_rs, directed_steps[i].t_byte, 16'd0,
                       directed_steps[i].t_after);
            pending_writes[pending_writes.size()-1].last = 1'b1;
         end
      end

      // random requests in three phases of sender gaps and receiver stalls
      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct = (phase == 0) ? 7 : (phase == 1) ? 69 : 0;
         recv_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 7 : 0;
         counted = 0;
         while (counted < RAND_PER_PHASE) begin
            pick = $urandom_range(99);
            ch = 8'($urandom);
            rq_row = 8'($urandom);
            rq_col = 8'($urandom);
            if (pick < 64) begin
               cmd = CMD_PUT;
               if (pick < 7)
                  ch = CHAR_LF;
               else if (pick < 11)
                  ch = CHAR_CR;
            end else if (pick < 84) begin
               cmd = CMD_SET;
               // mostly positions on the display, the rest clamped
               if ($urandom_range(2) != 0) begin
                  rq_row = 8'($urandom_range(LCD_ROWS - 1));
                  rq_col = 8'($urandom_range(LCD_COLS));
               end
            end else if (pick < 94) begin
               cmd = CMD_CLEAR;
            end else begin
               cmd = CMD_INIT;
            end
            send_request(cmd, ch, rq_row, rq_col);
            if (!(cmd == CMD_PUT && ch == CHAR_CR))
               counted++;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then watch for stray writes
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d directed), checked %0d bus writes,", n_requests,
               DIR_STEPS, n_writes);
      $display("including %0d init sequences and %0d row wraps, under three stall mixes.",
               n_inits, n_wraps);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
